// ===== sv/assert_macros.svh =====
// Assertion macros for the tokenizer RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== sv/sqltok_pkg.sv =====
// Shared types, constants and the keyword classifier for the SQL keyword tokenizer.
// No dependencies.
package sqltok_pkg;

	localparam int KW_CHARS    = 6;   // keyword prefix bytes kept per word
	localparam int POS_BITS    = 16;  // width of the character position
	localparam int LEN_BITS    = 8;   // word length, saturating
	localparam int KIND_BITS   = 4;
	localparam int NUM_KW      = 10;
	localparam int FIFO_DEPTH  = 4;   // result queue entries
	localparam int PTR_BITS    = $clog2(FIFO_DEPTH);
	localparam int CNT_BITS    = $clog2(FIFO_DEPTH + 1);
	localparam int IDX_BITS    = $clog2(KW_CHARS);
	localparam int TDATA_BITS  = 32;

	localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_MAIN   = 4'd0,
		KIND_LPAR   = 4'd1,
		KIND_RPAR   = 4'd2,
		KIND_COMMA  = 4'd3,
		KIND_TYPE   = 4'd4,
		KIND_SECOND = 4'd5,
		KIND_SEMI   = 4'd6,
		KIND_IDENT  = 4'd7,
		KIND_ERROR  = 4'd8
	} tok_kind_t;

	// Byte 0 of the word sits in element 0 (the leftmost byte of a string literal).
	typedef logic [0:KW_CHARS-1][7:0] prefix_t;

	typedef struct packed {
		prefix_t             text;
		logic [LEN_BITS-1:0] len;
		tok_kind_t           kind;
	} keyword_t;

	typedef struct packed {
		logic                last;
		logic [LEN_BITS-1:0] length;
		logic [POS_BITS-1:0] start;
		tok_kind_t           kind;
	} token_t;

	// Listed in priority order; shorter words are padded with zero bytes.
	localparam keyword_t KEYWORDS [NUM_KW] = '{
		'{"create",          8'd6, KIND_MAIN},
		'{{"table", 8'h00},  8'd5, KIND_MAIN},
		'{{"alter", 8'h00},  8'd5, KIND_MAIN},
		'{{"drop", 16'h0},   8'd4, KIND_MAIN},
		'{{"int", 24'h0},    8'd3, KIND_TYPE},
		'{{"date", 16'h0},   8'd4, KIND_TYPE},
		'{{"time", 16'h0},   8'd4, KIND_TYPE},
		'{{"text", 16'h0},   8'd4, KIND_TYPE},
		'{{"add", 24'h0},    8'd3, KIND_SECOND},
		'{"modify",          8'd6, KIND_SECOND}
	};

	function automatic logic is_ident_byte(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "0" && c <= "9") || c == "_";
	endfunction

	// Classify a completed word; the first keyword in table order wins.
	function automatic tok_kind_t word_class(input prefix_t p, input logic [LEN_BITS-1:0] len,
		input logic ident);
		tok_kind_t kind;
		logic      hit;
		kind = ident ? KIND_IDENT : KIND_ERROR;
		for (int k = NUM_KW - 1; k >= 0; k--) begin
			hit = (len == KEYWORDS[k].len);
			for (int i = 0; i < KW_CHARS; i++) begin
				if (LEN_BITS'(i) < KEYWORDS[k].len && p[i] != KEYWORDS[k].text[i])
					hit = 1'b0;
			end
			if (hit)
				kind = KEYWORDS[k].kind;
		end
		return kind;
	endfunction

endpackage

// ===== sv/sql_keyword_tokenizer_unit.sv =====
// Top level of the SQL keyword tokenizer: input register, word tracker and result queue.
// Depends on sqltok_pkg and assert_macros.svh.
//
//  channel  | dir | tdata (low bit up)                    | tlast
//  ---------+-----+---------------------------------------+---------------------------
//  s_*      | in  | text_char[7:0]                        | end_of_text
//  m_*      | out | token_kind[3:0] token_start[19:4]     | last_of_run (final token
//           |     | token_length[27:20], zero [31:28]     | of one character)
//
// One character per cycle while the result queue has room. A character is held in the
// input register, then is scanned against the pending word and its tokens (zero, one
// or two) enter a four-entry queue, which drives the output stream.
// The queue drains one token per cycle while m_tready is high; the input takes
// requests while the queue has room for two more tokens. Reset clears the word state,
// positions and the queue; the prefix bytes keep whatever they hold and are
// rewritten before they are read.
`include "assert_macros.svh"

module sql_keyword_tokenizer_unit
	import sqltok_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] text_char
	input  logic                  s_tlast,   // end_of_text
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [TDATA_BITS-1:0] m_tdata,   // [3:0] kind, [19:4] start, [27:20] length
	output logic                  m_tlast    // last_of_run
);

	// ---- input register ----
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eot_s1;

	// ---- word state ----
	logic [7:0]          prefix_q [KW_CHARS];
	logic [LEN_BITS-1:0] word_len_q;
	logic                ident_q;
	logic [POS_BITS-1:0] char_pos_q;
	logic [POS_BITS-1:0] word_start_q;

	// ---- result queue ----
	token_t              fifo_q [FIFO_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	logic                room;
	logic                scan;
	logic                pop;
	logic                is_space;
	logic                is_mark;
	logic                is_word;
	prefix_t             nxt_prefix;
	logic [LEN_BITS-1:0] nxt_len;
	logic                nxt_ident;
	logic [POS_BITS-1:0] nxt_start;
	logic                emit_word;
	tok_kind_t           mark_kind;
	token_t              word_tok;
	token_t              mark_tok;
	token_t              tok0;
	token_t              tok1;
	logic [1:0]          push_n;

	// Room for the two tokens a single character can cause; registered count only.
	assign room     = (count_q <= CNT_BITS'(FIFO_DEPTH - 2));
	assign scan     = valid_s1 && room;
	assign pop      = m_tvalid && m_tready;
	assign s_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			eot_s1  <= s_tlast;
		end
	end

	// ---- character scan ----
	always_comb begin
		is_space = (char_s1 == " ") || (char_s1 == 8'h09) || (char_s1 == 8'h0a);
		is_mark  = 1'b0;
		mark_kind = KIND_ERROR;
		case (char_s1)
			"(": begin is_mark = 1'b1; mark_kind = KIND_LPAR;  end
			")": begin is_mark = 1'b1; mark_kind = KIND_RPAR;  end
			",": begin is_mark = 1'b1; mark_kind = KIND_COMMA; end
			";": begin is_mark = 1'b1; mark_kind = KIND_SEMI;  end
			"[", "{", "}", ".": begin
				is_mark = 1'b1;
			end
			default: ;
		endcase
		is_word = !is_space && !is_mark;

		// Word as it stands after this character.
		for (int i = 0; i < KW_CHARS; i++) begin
			nxt_prefix[i] = (is_word && word_len_q == LEN_BITS'(i)) ? char_s1 : prefix_q[i];
		end
		nxt_len   = (is_word && word_len_q != LEN_MAX) ? word_len_q + 1'b1 : word_len_q;
		nxt_ident = ident_q && !(is_word && !is_ident_byte(char_s1));
		nxt_start = (is_word && word_len_q == '0) ? char_pos_q : word_start_q;

		emit_word = (!is_word || eot_s1) && (nxt_len != '0);

		word_tok.kind   = word_class(nxt_prefix, nxt_len, nxt_ident);
		word_tok.start  = nxt_start;
		word_tok.length = nxt_len;
		word_tok.last   = !is_mark;

		mark_tok.kind   = mark_kind;
		mark_tok.start  = char_pos_q;
		mark_tok.length = LEN_BITS'(1);
		mark_tok.last   = 1'b1;

		// Word token goes first, the mark after it.
		tok0   = emit_word ? word_tok : mark_tok;
		tok1   = mark_tok;
		push_n = scan ? (2'(emit_word) + 2'(is_mark)) : 2'd0;
	end

	// ---- word state update ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_len_q   <= '0;
			ident_q      <= 1'b1;
			char_pos_q   <= '0;
			word_start_q <= '0;
		end else if (scan) begin
			word_start_q <= nxt_start;
			char_pos_q   <= eot_s1 ? '0 : char_pos_q + 1'b1;
			if (!is_word || eot_s1) begin
				// Flush: drop the pending word.
				word_len_q <= '0;
				ident_q    <= 1'b1;
			end else begin
				word_len_q <= nxt_len;
				ident_q    <= nxt_ident;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < KW_CHARS; i++) begin
			if (scan && is_word && word_len_q == LEN_BITS'(i))
				prefix_q[i] <= char_s1;
		end
	end

	// ---- result queue ----
	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			fifo_q[wr_ptr_q] <= tok0;
		if (push_n == 2'd2)
			fifo_q[wr_ptr_q + 1'b1] <= tok1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_BITS'(push_n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + CNT_BITS'(push_n) - CNT_BITS'(pop);
		end
	end

	assign m_tvalid = (count_q != '0);
	assign m_tdata  = TDATA_BITS'({fifo_q[rd_ptr_q].length, fifo_q[rd_ptr_q].start,
		fifo_q[rd_ptr_q].kind});
	assign m_tlast  = fifo_q[rd_ptr_q].last;

	// ---- assertions ----
	`ASSERT_NEVER(a_queue_overflow, count_q > CNT_BITS'(FIFO_DEPTH),
		"result queue holds more than its depth")
	`ASSERT_CLK(a_pair_order, push_n == 2'd2 |-> (!tok0.last && tok1.last),
		"a two-token request must mark only the second token last")
	`ASSERT_CLK(a_empty_word_ident, word_len_q == '0 |-> ident_q,
		"empty word must carry a set identifier flag")
	`ASSERT_CLK(a_eot_restart, (scan && eot_s1) |=> (char_pos_q == '0 && word_len_q == '0),
		"end of text must restart positions and clear the word")

endmodule

// ===== test/sql_keyword_tokenizer_token_check.sv =====
// Token checker for the SQL keyword tokenizer: predicts the tokens of every accepted
// character and compares them with the tokens accepted on the output stream.
// Depends on sqltok_pkg.
module sql_keyword_tokenizer_token_check
	import sqltok_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] text_char
	input  logic                  s_tlast,   // end_of_text
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [TDATA_BITS-1:0] m_tdata,   // [3:0] kind, [19:4] start, [27:20] length
	input  logic                  m_tlast,   // last_of_run
	output int                    fail_count,
	output int                    awaited,
	output int                    tokens_seen
);

	localparam int MAX_REPORTS = 40;
	localparam int NUM_WORDS   = 10;

	typedef struct packed {
		tok_kind_t           kind;
		logic [POS_BITS-1:0] start;
		logic [LEN_BITS-1:0] length;
		logic                last;
	} token_exp_t;

	// Keywords in match priority order.
	string keyword_text [NUM_WORDS] = '{"create", "table", "alter", "drop", "int", "date",
		"time", "text", "add", "modify"};
	tok_kind_t keyword_kind [NUM_WORDS] = '{KIND_MAIN, KIND_MAIN, KIND_MAIN, KIND_MAIN,
		KIND_TYPE, KIND_TYPE, KIND_TYPE, KIND_TYPE, KIND_SECOND, KIND_SECOND};

	token_exp_t          expected_tokens [$];
	token_exp_t          step_tokens [2];
	int                  step_count;
	logic [7:0]          word_bytes [KW_CHARS];
	logic [LEN_BITS-1:0] word_len;
	logic                word_ident;
	logic [POS_BITS-1:0] char_pos;
	logic [POS_BITS-1:0] word_pos;
	int                  errors;
	int                  seen;

	function automatic tok_kind_t classify_word();
		tok_kind_t kind;
		logic      found;
		logic      same;
		kind  = word_ident ? KIND_IDENT : KIND_ERROR;
		found = 1'b0;
		for (int k = 0; k < NUM_WORDS; k++) begin
			if (!found && int'(word_len) == keyword_text[k].len()) begin
				same = 1'b1;
				for (int i = 0; i < keyword_text[k].len(); i++)
					if (word_bytes[i] != keyword_text[k][i])
						same = 1'b0;
				if (same) begin
					kind  = keyword_kind[k];
					found = 1'b1;
				end
			end
		end
		return kind;
	endfunction

	function automatic void close_word();
		if (word_len != '0) begin
			step_tokens[step_count] = '{classify_word(), word_pos, word_len, 1'b0};
			step_count++;
		end
		word_len   = '0;
		word_ident = 1'b1;
	endfunction

	// Advance the word state by one character and queue the tokens it completes.
	function automatic void scan_char(input logic [7:0] c, input logic eot);
		logic [POS_BITS-1:0] pos;
		tok_kind_t           mark;
		pos        = char_pos;
		step_count = 0;
		case (c)
			" ", "\t", "\n": close_word();
			"(", ")", "[", "{", "}", ".", ",", ";": begin
				close_word();
				case (c)
					"(":     mark = KIND_LPAR;
					")":     mark = KIND_RPAR;
					",":     mark = KIND_COMMA;
					";":     mark = KIND_SEMI;
					default: mark = KIND_ERROR;
				endcase
				step_tokens[step_count] = '{mark, pos, LEN_BITS'(1), 1'b0};
				step_count++;
			end
			default: begin
				if (word_len == '0)
					word_pos = pos;
				if (word_len < KW_CHARS)
					word_bytes[word_len] = c;
				if (!((c >= "a" && c <= "z") || (c >= "0" && c <= "9") || c == "_"))
					word_ident = 1'b0;
				if (word_len != LEN_MAX)
					word_len++;
			end
		endcase
		char_pos = pos + 1'b1;
		if (eot) begin
			close_word();
			char_pos = '0;
		end
		if (step_count > 0)
			step_tokens[step_count - 1].last = 1'b1;
		for (int i = 0; i < step_count; i++)
			expected_tokens = {expected_tokens, step_tokens[i]};
	endfunction

	function automatic void check_field(input string field, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$error("%s: expected %0d, got %0d", field, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		token_exp_t want;
		if (!arst_n) begin
			expected_tokens.delete();
			word_len    = '0;
			word_ident  = 1'b1;
			char_pos    = '0;
			word_pos    = '0;
			errors      = 0;
			seen        = 0;
			fail_count  <= 0;
			awaited     <= 0;
			tokens_seen <= 0;
		end else begin
			if (s_tvalid && s_tready)
				scan_char(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				seen++;
				if (expected_tokens.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$error("token_kind %0d at start %0d arrived with no token expected",
							m_tdata[3:0], m_tdata[19:4]);
				end else begin
					want = expected_tokens.pop_front();
					check_field("token_kind", want.kind, m_tdata[3:0]);
					check_field("token_start", want.start, m_tdata[19:4]);
					check_field("token_length", want.length, m_tdata[27:20]);
					check_field("last_of_run", want.last, m_tlast);
					check_field("tdata padding", 0, m_tdata[TDATA_BITS-1:28]);
				end
			end
			fail_count  <= errors;
			awaited     <= expected_tokens.size();
			tokens_seen <= seen;
		end
	end

endmodule

// ===== test/sql_keyword_tokenizer_unit_test.sv =====
// Testbench top for the SQL keyword tokenizer: drives query text, stalls the token
// stream and gives the verdict. Depends on sqltok_pkg, the unit and the token checker.
module sql_keyword_tokenizer_unit_test;
	import sqltok_pkg::*;

	localparam int QUIET_LIMIT  = 1000;   // cycles without any request before giving up
	localparam int PHASE_CHARS  = 420;    // minimum characters per idling mix
	localparam int LONG_WORD    = 300;    // directed word well past the length limit
	localparam int DRAIN_CYCLES = 20;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [TDATA_BITS-1:0] m_tdata;
	logic                  m_tlast;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int fail_count;
	int awaited;
	int tokens_seen;
	int chars_sent     = 0;
	int quiet_cycles   = 0;

	logic [7:0] text_q [$];

	string sql_words [10] = '{"create", "table", "alter", "drop", "int", "date", "time",
		"text", "add", "modify"};
	string word_chars = "abcdefghijklmnopqrstuvwxyz0123456789_";
	string marks      = "()[{}.,;";

	sql_keyword_tokenizer_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	sql_keyword_tokenizer_token_check i_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.fail_count  (fail_count),
		.awaited     (awaited),
		.tokens_seen (tokens_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stall the token stream at the rate of the current phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Give up when neither stream moves a request for too long; this also catches
	// tokens that never come out.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Append one byte to the text under construction.
	function automatic void add_char(input logic [7:0] c);
		text_q = {text_q, c};
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i]);
	endfunction

	function automatic void add_ident(input int len);
		for (int i = 0; i < len; i++)
			add_char(word_chars[$urandom_range(word_chars.len() - 1)]);
	endfunction

	// Any byte at all, separators and marks included.
	function automatic void add_bytes(input int len);
		for (int i = 0; i < len; i++)
			add_char(8'($urandom_range(255)));
	endfunction

	function automatic void add_break();
		int r;
		r = $urandom_range(9);
		if (r < 4)
			add_char(" ");
		else if (r == 4)
			add_char("\t");
		else if (r == 5)
			add_char("\n");
		else
			add_char(marks[$urandom_range(marks.len() - 1)]);
	endfunction

	// Build one statement: mostly keywords and identifiers split by whitespace and
	// marks, with near-miss keywords, raw bytes and now and then a very long word.
	function automatic void add_statement();
		int    words;
		int    r;
		string w;
		if ($urandom_range(9) == 0) begin
			add_bytes($urandom_range(20, 1));
			return;
		end
		words = $urandom_range(12, 2);
		for (int n = 0; n < words; n++) begin
			r = $urandom_range(99);
			w = sql_words[$urandom_range(9)];
			if (r < 40)
				add_text(w);
			else if (r < 48) begin
				add_text(w);
				add_ident(1);
			end else if (r < 54)
				add_text(w.substr(0, w.len() - 2));
			else if (r < 58)
				add_text(w.toupper());
			else if (r < 70)
				add_bytes($urandom_range(4, 1));
			else if ($urandom_range(49) == 0)
				add_ident($urandom_range(320, 250));
			else
				add_ident($urandom_range(9, 1));
			// Leave a break out now and then so that words run together.
			if ($urandom_range(9) != 0)
				add_break();
		end
		if ($urandom_range(1) == 0)
			add_char(";");
	endfunction

	// Offer one character; hold it until the block takes it.
	task automatic send_char(input logic [7:0] c, input logic eot);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= eot;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		chars_sent++;
	endtask

	// Send the built text and drop it; flag its final character as end of text if with_eot.
	task automatic send_text(input logic with_eot);
		for (int i = 0; i < text_q.size(); i++)
			send_char(text_q[i], with_eot && (i == text_q.size() - 1));
		text_q.delete();
	endtask

	// Drop valid and wait until every predicted token has come out.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct);
		int first;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		first          = chars_sent;
		while (chars_sent - first < PHASE_CHARS) begin
			add_statement();
			send_text(1'b1);
		end
		wait_drained();
	endtask

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		m_tready <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed texts: a keyword and a word closed by marks, the last mark ending the
		// text, marks without a meaning and a semicolon, the byte extremes as one error
		// word flushed at end of text, identifier bytes split by tab and newline, and a
		// word long enough to saturate its length.
		add_text("int(a),");
		send_text(1'b1);
		add_text("[{}.;");
		send_text(1'b1);
		add_char(8'h00);
		add_char(8'hFF);
		add_char(8'h80);
		send_text(1'b1);
		add_text("_9z\tq\n");
		send_text(1'b1);
		add_ident(LONG_WORD);
		add_text(" x");
		send_text(1'b1);
		wait_drained();

		// Random statements under each idling mix.
		run_phase(0, 0);
		run_phase(49, 0);
		run_phase(0, 49);
		run_phase(11, 11);

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d characters and %0d tokens over all idling mixes,",
			chars_sent, tokens_seen);
		$display("with every mark, every keyword, raw bytes and saturated word lengths.");
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/sqltok_pkg.sv
sv/sql_keyword_tokenizer_unit.sv
test/sql_keyword_tokenizer_token_check.sv
test/sql_keyword_tokenizer_unit_test.sv
